>>> src/bis_pkg.sv
// Shared types, field widths, register codes and defaults for the bilinear scaler.
// No dependencies; bis_mac and the top level import this package, bis_ram uses none.
`default_nettype none
package bis_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF   = 512;
  localparam int MAX_HEIGHT_DEF  = 512;
  localparam int WEIGHT_BITS_DEF = 8;

  // Fixed field widths
  localparam int CMD_W   = 1;
  localparam int SRC_W   = 9;
  localparam int PIX_W   = 8;
  localparam int DEST_W  = 11;
  localparam int SIZE_W  = 10;
  localparam int SCALE_W = 17;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = DEST_W + SCALE_W;
  localparam int CFG_IDX_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RESAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE = 2'd2;

  // Register reset values
  localparam logic [SIZE_W-1:0]  SOURCE_WIDTH_RST  = 10'd512;
  localparam logic [SIZE_W-1:0]  SOURCE_HEIGHT_RST = 10'd512;
  localparam logic [SCALE_W-1:0] INVERSE_SCALE_RST = 17'd50412;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SRC_W-1:0]  src_col;
    logic [SRC_W-1:0]  src_row;
    logic [PIX_W-1:0]  src_pixel;
    logic [DEST_W-1:0] dest_col;
    logic [DEST_W-1:0] dest_row;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0]  result_pixel;
    logic [DEST_W-1:0] result_col;
    logic [DEST_W-1:0] result_row;
  } res_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic load;
    logic accum;
  } mac_ctrl_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

>>> src/bis_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Uses no package.
`default_nettype none
module bis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/bis_mac.sv
// Shared multiply-accumulate unit: one multiplier feeding a registered accumulator.
// Depends on bis_pkg (mac_ctrl_t).
`default_nettype none
module bis_mac #(
  parameter int A_W   = 16,
  parameter int B_W   = 17,
  parameter int ACC_W = 28
) (
  input  wire logic                      clk,
  input  wire logic [A_W-1:0]            a,
  input  wire logic [B_W-1:0]            b,
  input  wire bis_pkg::mac_ctrl_t        ctrl,
  output logic      [ACC_W-1:0]          acc
);
  import bis_pkg::*;

  logic [A_W+B_W-1:0] prod;

  assign prod = a * b;

  // Operands are chosen so every product and partial sum fits ACC_W.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= ACC_W'(prod);
    end else if (ctrl.accum) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule
`default_nettype wire

>>> src/bilinear_image_scaler.sv
// Bilinear image scaler, top level. Write: accepted only while idle, no result. Resample:
// request accepted, then 2 position products, 4 frame reads, 6 MAC steps on the one
// shared multiplier and 1 result step; no new request is taken until the sequencer
// is idle again. Border hits skip the blend and go from the address step straight to
// the result step. A stalled result holds the sequencer in its last step.
// Sync reset clears sequencer, result valid and config regs; the frame store is not.
`default_nettype none
module bilinear_image_scaler #(
  parameter int MAX_WIDTH   = bis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bis_pkg::MAX_HEIGHT_DEF,
  parameter int WEIGHT_BITS = bis_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request channel
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire bis_pkg::req_t                  req,
  // result channel
  output logic                                res_valid,
  input  wire logic                           res_stall,
  output bis_pkg::res_t                       res,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bis_pkg::SCALE_W-1:0]    cfg_data
);
  import bis_pkg::*;

  // Frame store geometry: address = {row, col}
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = CW + RW;
  localparam int DEPTH  = MAX_HEIGHT * (1 << CW);

  // MAC operand and accumulator widths
  localparam int WB    = WEIGHT_BITS;
  localparam int ROW_W = PIX_W + WB;                   // one blended row, <= 255*S
  localparam int A_W   = max_int(ROW_W, DEST_W);
  localparam int B_W   = max_int(WB + 1, SCALE_W);
  localparam int ACC_W = max_int(PIX_W + 2 * WB, POS_W);

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_POSX, S_POSY, S_ADDR,
    S_H0, S_H1, S_H2, S_H3, S_V0, S_V1, S_FIN
  } state_t;

  state_t state;

  // Configuration registers
  logic [SIZE_W-1:0]  source_width;
  logic [SIZE_W-1:0]  source_height;
  logic [SCALE_W-1:0] inverse_scale;

  // Datapath registers
  logic [DEST_W-1:0] item_col;
  logic [DEST_W-1:0] item_row;
  logic [POS_W-1:0]  pos_x;
  logic [WB-1:0]     fx;
  logic [WB-1:0]     fy;
  logic [CW-1:0]     col_base;
  logic [RW-1:0]     row_base;
  logic [ROW_W-1:0]  top_row;
  logic [ROW_W-1:0]  bot_row;
  logic              res_zero;

  // MAC and RAM wiring
  logic [A_W-1:0]    mac_a;
  logic [B_W-1:0]    mac_b;
  mac_ctrl_t         mac_ctrl;
  logic [ACC_W-1:0]  acc;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;

  // Address-stage signals
  logic [POS_W-1:0]  pos_y;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] lim_x;
  logic [SIZE_W-1:0] lim_y;
  logic              outside;
  logic [WB:0]       wfx_inv;
  logic [WB:0]       wfy_inv;
  logic [WB-1:0]     fy_now;
  logic              req_accept;
  logic              res_accept;

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign res_accept = res_valid && !res_stall;
  assign cfg_ready  = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SOURCE_WIDTH_RST;
      source_height <= SOURCE_HEIGHT_RST;
      inverse_scale <= INVERSE_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SOURCE_WIDTH:  source_width  <= cfg_data[SIZE_W-1:0];
        CFG_SOURCE_HEIGHT: source_height <= cfg_data[SIZE_W-1:0];
        CFG_INVERSE_SCALE: inverse_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Border test. Sizes clamp to the store; a size below two leaves limit 0,
  // so every position counts as outside. Compare in full Q.16.
  // --------------------------------------------------------------------------
  assign pos_y   = acc[POS_W-1:0];
  assign w_eff   = (32'(source_width)  > MAX_WIDTH)  ? SIZE_W'(MAX_WIDTH)  : source_width;
  assign h_eff   = (32'(source_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : source_height;
  assign lim_x   = (w_eff == '0) ? '0 : w_eff - 1'b1;
  assign lim_y   = (h_eff == '0) ? '0 : h_eff - 1'b1;
  assign outside = (pos_x >= POS_W'({lim_x, {FRAC_W{1'b0}}})) ||
                   (pos_y >= POS_W'({lim_y, {FRAC_W{1'b0}}}));
  assign fy_now  = pos_y[FRAC_W-1 -: WB];

  // complementary weights S - f
  assign wfx_inv = {1'b1, {WB{1'b0}}} - {1'b0, fx};
  assign wfy_inv = {1'b1, {WB{1'b0}}} - {1'b0, fy};

  // --------------------------------------------------------------------------
  // Frame store: writes only while idle, reads only while busy
  // --------------------------------------------------------------------------
  assign ram_we    = req_accept && (req.cmd == CMD_WRITE) &&
                     (32'(req.src_col) < MAX_WIDTH) && (32'(req.src_row) < MAX_HEIGHT);
  assign ram_waddr = {RW'(req.src_row), CW'(req.src_col)};

  // Neighbor reads: (ix,iy) in ADDR, then (ix+1,iy), (ix,iy+1), (ix+1,iy+1).
  // The border test guarantees ix+1 and iy+1 stay inside the store.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {row_base, col_base};
    case (state)
      S_ADDR: begin
        ram_re    = 1'b1;
        ram_raddr = {pos_y[FRAC_W +: RW], pos_x[FRAC_W +: CW]};
      end
      S_H0: begin
        ram_re    = 1'b1;
        ram_raddr = {row_base, col_base + 1'b1};
      end
      S_H1: begin
        ram_re    = 1'b1;
        ram_raddr = {row_base + 1'b1, col_base};
      end
      S_H2: begin
        ram_re    = 1'b1;
        ram_raddr = {row_base + 1'b1, col_base + 1'b1};
      end
      default: ;
    endcase
  end

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.src_pixel),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared MAC schedule
  //   POSX: acc = col*inv       POSY: acc = row*inv
  //   H0/H1: acc = P00*(S-fx) + P01*fx       (top row)
  //   H2/H3: acc = P10*(S-fx) + P11*fx       (bottom row)
  //   V0/V1: acc = top*(S-fy) + bot*fy       (final sum, 2*WB frac bits)
  // --------------------------------------------------------------------------
  always_comb begin
    mac_a    = A_W'(ram_rdata);
    mac_b    = B_W'(wfx_inv);
    mac_ctrl = '{load: 1'b0, accum: 1'b0};
    case (state)
      S_POSX: begin
        mac_a         = A_W'(item_col);
        mac_b         = B_W'(inverse_scale);
        mac_ctrl.load = 1'b1;
      end
      S_POSY: begin
        mac_a         = A_W'(item_row);
        mac_b         = B_W'(inverse_scale);
        mac_ctrl.load = 1'b1;
      end
      S_H0, S_H2: begin
        mac_b         = B_W'(wfx_inv);
        mac_ctrl.load = 1'b1;
      end
      S_H1, S_H3: begin
        mac_b          = B_W'(fx);
        mac_ctrl.accum = 1'b1;
      end
      S_V0: begin
        mac_a         = A_W'(top_row);
        mac_b         = B_W'(wfy_inv);
        mac_ctrl.load = 1'b1;
      end
      S_V1: begin
        mac_a          = A_W'(bot_row);
        mac_b          = B_W'(fy);
        mac_ctrl.accum = 1'b1;
      end
      default: ;
    endcase
  end

  bis_mac #(
    .A_W   (A_W),
    .B_W   (B_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .a    (mac_a),
    .b    (mac_b),
    .ctrl (mac_ctrl),
    .acc  (acc)
  );

  // --------------------------------------------------------------------------
  // Sequencer, datapath registers and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // in FIN an accepted result is replaced by the new one below
      if (res_accept && (state != S_FIN)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_accept && (req.cmd == CMD_RESAMPLE)) begin
            item_col <= req.dest_col;
            item_row <= req.dest_row;
            state    <= S_POSX;
          end
        end
        S_POSX: state <= S_POSY;
        S_POSY: begin
          pos_x <= acc[POS_W-1:0];
          state <= S_ADDR;
        end
        S_ADDR: begin
          // pos_y is still in the accumulator here
          fx       <= pos_x[FRAC_W-1 -: WB];
          fy       <= fy_now;
          col_base <= pos_x[FRAC_W +: CW];
          row_base <= pos_y[FRAC_W +: RW];
          res_zero <= outside;
          state    <= outside ? S_FIN : S_H0;
        end
        S_H0: state <= S_H1;
        S_H1: state <= S_H2;
        S_H2: begin
          top_row <= acc[ROW_W-1:0];
          state   <= S_H3;
        end
        S_H3: state <= S_V0;
        S_V0: begin
          bot_row <= acc[ROW_W-1:0];
          state   <= S_V1;
        end
        S_V1: state <= S_FIN;
        S_FIN: begin
          // wait for the result register to free up
          if (!res_valid || res_accept) begin
            // weights sum to S*S, so the sum >> 2*WB never exceeds 255:
            // the 8-bit field is already the saturated value
            res.result_pixel <= res_zero ? '0 : acc[2 * WB +: PIX_W];
            res.result_col   <= item_col;
            res.result_row   <= item_row;
            res_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a write request never raises a result
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (req_accept && (req.cmd == CMD_WRITE) && !res_valid) |=> !res_valid)
    else $error("write request produced a result");

  // a resample request makes the block busy on the next cycle
  a_resample_busy: assert property (@(posedge clk) disable iff (rst)
    (req_accept && (req.cmd == CMD_RESAMPLE)) |=> req_stall)
    else $error("resample request did not start the sequencer");

  // a new result carries the coordinates of the request it came from
  a_result_coords: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> (res.result_col == item_col) && (res.result_row == item_row))
    else $error("result coordinates do not match request");

endmodule
`default_nettype wire
